/* src/ipct_pkg.sv */
// Package: shared types, opcodes and constants of the channel table.
`timescale 1ns / 1ps
`default_nettype none
package ipct_pkg;
	localparam int CHANNELS_DEF     = 128;
	localparam int BUFFER_BYTES_DEF = 4096;
	localparam int PID_W  = 15;
	localparam int REQ_W  = 16;
	localparam int ID_W   = 7;
	localparam int CNT_W  = 13;
	localparam int OFS_W  = 12;

	localparam logic [2:0] OP_OPEN   = 3'd0;
	localparam logic [2:0] OP_CLOSE  = 3'd1;
	localparam logic [2:0] OP_WRITE  = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_GETW   = 3'd4;
	localparam logic [2:0] OP_GETR   = 3'd5;
	localparam logic [2:0] OP_READY  = 3'd6;
	localparam logic [2:0] OP_CLOSEA = 3'd7;

	localparam logic [1:0] RC_OK   = 2'd0;
	localparam logic [1:0] RC_NOP  = 2'd1;
	localparam logic [1:0] RC_BUSY = 2'd2;
	localparam logic [1:0] RC_NONE = 2'd3;

	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READY = 2'd2;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [ID_W-1:0]  channel_id;
		logic [PID_W-1:0] caller_pid;
		logic [PID_W-1:0] peer_pid;
		logic [REQ_W-1:0] request_size;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       result_code;
		logic [ID_W-1:0]  channel_out;
		logic [CNT_W-1:0] byte_count;
		logic [OFS_W-1:0] buffer_offset;
		logic [PID_W-1:0] pid_out;
	} rsp_t;
endpackage
`default_nettype wire

/* src/ipct_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ipct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* src/ipct_front.sv */
// Front: input acceptance into a two-entry command queue.
`timescale 1ns / 1ps
`default_nettype none
module ipct_front import ipct_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cmd_t in_cmd,
	output logic      q_valid,
	input  wire logic q_pop,
	output cmd_t      q_cmd
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;
	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rp_q];
	always_ff @(posedge clk) if (push) mem_q[wp_q] <= in_cmd;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

/* src/ipct_back.sv */
// Back: table sequencer that executes one command at a time.
`timescale 1ns / 1ps
`default_nettype none
module ipct_back import ipct_pkg::*; #(
	parameter int CHANNELS     = CHANNELS_DEF,
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	output logic      q_pop,
	input  wire cmd_t q_cmd,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);
	localparam int AW = $clog2(CHANNELS);
	localparam int SW = $clog2(BUFFER_BYTES + 1);
	localparam int EW = 2 + SW + SW + 2 * PID_W;
	typedef struct packed {
		logic [1:0]       status;
		logic [SW-1:0]    size;
		logic [SW-1:0]    offset;
		logic [PID_W-1:0] reader;
		logic [PID_W-1:0] writer;
	} ent_t;

	localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_EXEC = 3'd2,
		S_OUT = 3'd4;
	logic [2:0] state_q;
	cmd_t cmd_q;
	logic [AW-1:0] idx_q;
	logic [CHANNELS-1:0] vld_q;
	logic rvld_q;
	rsp_t rsp_q;

	logic we;
	logic [AW-1:0] addr;
	logic [AW-1:0] waddr;
	ent_t wdata, rdata_raw, e;
	logic [EW-1:0] rbits;

	ipct_ram #(.WIDTH(EW), .DEPTH(CHANNELS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(addr), .rdata(rbits));
	assign rdata_raw = ent_t'(rbits);
	// entry with cleared valid bit reads as reset value
	assign e = rvld_q ? rdata_raw : '0;

	logic id_ok;
	logic last;
	logic party;
	logic [SW-1:0] n_clamp;
	logic [REQ_W:0] req_x;
	assign id_ok = ({{(32-ID_W){1'b0}}, cmd_q.channel_id} < 32'(CHANNELS))
		&& (e.status != ST_FREE);
	assign last = (32'(idx_q) == CHANNELS - 1);
	assign party = (e.writer == cmd_q.caller_pid) || (e.reader == cmd_q.caller_pid);
	assign req_x = {1'b0, cmd_q.request_size};
	assign n_clamp = (32'(cmd_q.request_size) > BUFFER_BYTES) ? SW'(BUFFER_BYTES)
		: SW'(cmd_q.request_size);

	ent_t nw;
	rsp_t nr;
	logic do_we, done;
	always_comb begin
		nw = e; nr = '0; do_we = 1'b0; done = 1'b1;
		unique case (cmd_q.opcode)
			OP_OPEN: begin
				if (e.status == ST_FREE) begin
					nw.status = ST_IDLE; nw.writer = cmd_q.caller_pid;
					nw.reader = cmd_q.peer_pid; nw.offset = '0;
					do_we = 1'b1; nr.channel_out = ID_W'(idx_q);
				end else if (last) nr.result_code = RC_NONE;
				else done = 1'b0;
			end
			OP_READY: begin
				if (e.status == ST_READY && e.reader == cmd_q.caller_pid)
					nr.channel_out = ID_W'(idx_q);
				else if (last) nr.result_code = RC_NONE;
				else done = 1'b0;
			end
			OP_CLOSEA: begin
				if (e.status != ST_FREE && party) begin
					nw = '0; do_we = 1'b1;
				end
				done = last;
			end
			OP_CLOSE: begin
				if (!id_ok || !party) nr.result_code = RC_NOP;
				else begin nw = '0; do_we = 1'b1; end
			end
			OP_WRITE: begin
				if (!id_ok || cmd_q.request_size == '0) nr.result_code = RC_NOP;
				else if (e.status != ST_IDLE) nr.result_code = RC_BUSY;
				else begin
					nw.size = n_clamp; nw.offset = '0; nw.status = ST_READY;
					if (e.reader == cmd_q.caller_pid) begin
						nw.reader = e.writer; nw.writer = cmd_q.caller_pid;
					end
					do_we = 1'b1; nr.byte_count = CNT_W'(n_clamp);
				end
			end
			OP_READ: begin
				if (!id_ok || cmd_q.request_size == '0) nr.result_code = RC_NOP;
				else if (e.status != ST_READY || e.reader != cmd_q.caller_pid)
					nr.result_code = RC_BUSY;
				else begin
					nr.buffer_offset = OFS_W'(e.offset);
					if (req_x >= (REQ_W+1)'(e.size)) begin
						nr.byte_count = CNT_W'(e.size);
						nw.status = ST_IDLE; nw.offset = '0; nw.size = '0;
					end else begin
						nr.byte_count = CNT_W'(cmd_q.request_size);
						nw.offset = e.offset + SW'(cmd_q.request_size);
						nw.size = e.size - SW'(cmd_q.request_size);
					end
					do_we = 1'b1;
				end
			end
			default: begin
				if (!id_ok) nr.result_code = RC_NOP;
				else nr.pid_out = (cmd_q.opcode == OP_GETW) ? e.writer : e.reader;
			end
		endcase
	end

	logic is_scan;
	assign is_scan = (q_cmd.opcode == OP_OPEN) || (q_cmd.opcode == OP_READY)
		|| (q_cmd.opcode == OP_CLOSEA);
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign we = (state_q == S_EXEC) && do_we;
	assign wdata = nw;
	// write back always goes to the entry just examined
	assign waddr = idx_q;
	always_comb begin
		if (state_q == S_IDLE) addr = is_scan ? '0 : AW'(q_cmd.channel_id);
		else if (state_q == S_EXEC && !done) addr = idx_q + AW'(1);
		else addr = idx_q;
	end
	assign rsp_valid = (state_q == S_OUT);
	assign rsp = rsp_q;

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_cmd;
		if (state_q == S_EXEC && done) rsp_q <= nr;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; idx_q <= '0; vld_q <= '0; rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[addr];
			if (we) vld_q[waddr] <= 1'b1;
			unique case (state_q)
				S_IDLE: if (q_valid) begin
					idx_q <= addr; state_q <= S_RD;
				end
				S_RD: state_q <= S_EXEC;
				S_EXEC: begin
					if (done) state_q <= S_OUT;
					else begin idx_q <= addr; state_q <= S_RD; end
				end
				S_OUT: if (rsp_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* src/ipc_channel_table_unit.sv */
// Top level of the IPC channel table command unit.
//
// Usage: commands arrive on the s_axis channel, one per transaction; each
// produces exactly one result transaction on m_axis, in order.
// A two-entry command queue decouples acceptance from execution, so the
// sender can push up to two commands while a result is still waiting.
// Sequencing: close, write, read and pid queries read the table entry,
// execute, then present the result in an output state. Open, ready and
// close-all walk the table one entry at a time (read, then execute),
// stopping at a match or the last entry; close-all always walks every
// entry. The single table RAM paces the walk.
// Reset clears every channel to free at once through per-entry valid bits;
// no clearing pass is needed and commands are accepted right after reset.
// When the receiver stalls, the result holds on m_axis, execution stops
// and the queue fills, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module ipc_channel_table_unit import ipct_pkg::*; #(
	parameter int CHANNELS     = CHANNELS_DEF,
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// opcode[2:0], channel_id[9:3], caller_pid[24:10], peer_pid[39:25],
	// request_size[55:40]
	input  wire logic [55:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// result_code[1:0], channel_out[8:2], byte_count[21:9],
	// buffer_offset[33:22], pid_out[48:34], zero fill [55:49]
	output logic      [55:0] m_axis_tdata
);
	cmd_t in_cmd, q_cmd;
	rsp_t rsp;
	logic q_valid, q_pop;

	assign in_cmd.opcode       = s_axis_tdata[2:0];
	assign in_cmd.channel_id   = s_axis_tdata[9:3];
	assign in_cmd.caller_pid   = s_axis_tdata[24:10];
	assign in_cmd.peer_pid     = s_axis_tdata[39:25];
	assign in_cmd.request_size = s_axis_tdata[55:40];

	ipct_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready), .in_cmd(in_cmd),
		.q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

	ipct_back #(.CHANNELS(CHANNELS), .BUFFER_BYTES(BUFFER_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_cmd(q_cmd), .rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready),
		.rsp(rsp));

	assign m_axis_tdata = {7'd0, rsp.pid_out, rsp.buffer_offset, rsp.byte_count,
		rsp.channel_out, rsp.result_code};

	// a command is popped only when the queue holds one
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	// no command starts while a result waits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> !$past(q_pop) && m_axis_tvalid)
		else $error("result dropped");
	// byte counts never exceed the buffer
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> 32'(m_axis_tdata[21:9]) <= BUFFER_BYTES)
		else $error("byte count too large");
endmodule
`default_nettype wire
